FILE: rtl/emissive_light_top_k_select_assert.svh
// assertion macros for the light selector
// used by emissive_light_top_k_select; no other dependencies
`ifndef EMISSIVE_LIGHT_TOP_K_SELECT_ASSERT_SVH
`define EMISSIVE_LIGHT_TOP_K_SELECT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define ELK_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle
`define ELK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/elk_pkg.sv
// constants and helpers for the emissive light selector
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package elk_pkg;
    localparam int DEF_MAX_LIGHTS = 8;
    localparam logic [1:0] REG_CAM_X = 2'd0;
    localparam logic [1:0] REG_CAM_Y = 2'd1;
    localparam logic [1:0] REG_CAM_Z = 2'd2;
    localparam int SLOT_W = 24 + 24 + 24 + 22 + 63 + 32;

    // luminance, weights in units of 2^-16
    function automatic logic [20:0] lum21(input logic [20:0] r, input logic [20:0] g,
                                          input logic [20:0] b);
        logic [37:0] s;
        s = 38'(r) * 38'd13933 + 38'(g) * 38'd46871 + 38'(b) * 38'd4732;
        return s[36:16];
    endfunction
endpackage

`default_nettype wire

FILE: rtl/elk_ram.sv
// generic single port write, single port read ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module elk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

`default_nettype wire

FILE: rtl/emissive_light_top_k_select.sv
// Emissive light selector. Each accepted word carries at most one emissive body; the block
// derives range, colour and a distance-weighted score and keeps the MAX_LIGHTS best in a slot
// RAM (one entry per light, registered read). From acceptance until the input is ready again
// a body passes the setup states C1 to C3, a 25-step square root for the camera distance, a
// state to form the divisor, a 46-step restoring divide for the score and the slot write; a
// full table adds a scan of the score RAM. A skipped body is not processed. On frame end the
// kept lights go out in descending score order; each output word costs a selection pass over
// the kept entries plus a fetch. One word is handled at a time; a new word is taken while a
// finished word waits at the output.
// depends on elk_pkg, elk_ram and emissive_light_top_k_select_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "emissive_light_top_k_select_assert.svh"

module emissive_light_top_k_select
    import elk_pkg::*;
#(
    parameter int MAX_LIGHTS = DEF_MAX_LIGHTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        has_body,
    input  wire logic [23:0] pos_x,
    input  wire logic [23:0] pos_y,
    input  wire logic [23:0] pos_z,
    input  wire logic [15:0] radius,
    input  wire logic [15:0] emit_r,
    input  wire logic [15:0] emit_g,
    input  wire logic [15:0] emit_b,
    input  wire logic [15:0] emit_strength,
    input  wire logic        frame_end,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [23:0]      light_x,
    output logic [23:0]      light_y,
    output logic [23:0]      light_z,
    output logic [21:0]      light_range,
    output logic [20:0]      light_r,
    output logic [20:0]      light_g,
    output logic [20:0]      light_b,
    output logic [31:0]      light_score,
    output logic             rank_last
);
    localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CW = $clog2(MAX_LIGHTS + 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(MAX_LIGHTS);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_C1    = 4'd1;
    localparam logic [3:0] ST_C2    = 4'd2;
    localparam logic [3:0] ST_C3    = 4'd3;
    localparam logic [3:0] ST_SQRT  = 4'd4;
    localparam logic [3:0] ST_DEN   = 4'd5;
    localparam logic [3:0] ST_DIV   = 4'd6;
    localparam logic [3:0] ST_SCAN  = 4'd7;
    localparam logic [3:0] ST_WRITE = 4'd8;
    localparam logic [3:0] ST_SEL   = 4'd9;
    localparam logic [3:0] ST_FETCH = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0] state_reg, state_next;

    // camera registers
    logic [23:0] cam_x_reg, cam_y_reg, cam_z_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_x_reg <= '0;
            cam_y_reg <= '0;
            cam_z_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CAM_X: cam_x_reg <= cfg_data;
                REG_CAM_Y: cam_y_reg <= cfg_data;
                REG_CAM_Z: cam_z_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // captured body
    logic [23:0] px_reg, py_reg, pz_reg;
    logic [15:0] rad_reg, er_reg, eg_reg, eb_reg, st_reg;
    logic        fe_reg;
    logic [12:0] t_reg;
    logic [21:0] range_reg;
    logic [20:0] cr_reg, cg_reg, cb_reg;
    logic [20:0] lumc_reg;
    logic [20:0] lume_reg;
    logic [16:0] mult_reg;
    logic [49:0] sq_acc_reg;
    logic [1:0]  axis_reg;
    logic [42:0] prod_reg;

    // square root unit
    logic [49:0] sq_rem_reg;
    logic [49:0] sq_val_reg;
    logic [24:0] sq_res_reg;
    logic [4:0]  step_reg;

    // divider
    logic [45:0] num_reg;
    logic [32:0] den_reg;
    logic [33:0] drem_reg;
    logic [45:0] quo_reg;
    logic [5:0]  dstep_reg;
    logic [31:0] score_reg;

    // scan
    logic [AW-1:0]  scan_idx_reg;
    logic [CW-1:0]  scan_cnt_reg;
    logic [AW-1:0]  best_idx_reg;
    logic [31:0]    best_score_reg;
    logic           best_ok_reg;
    logic [CW-1:0]  kept_reg;
    logic [CW-1:0]  emitted_reg;
    logic [MAX_LIGHTS-1:0] done_reg;
    logic [AW-1:0]  wr_idx_reg;

    // ram ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    logic [SLOT_W-33:0]  ram_wdata, ram_rdata;
    logic [31:0]         sc_wdata, sc_rdata;

    elk_ram #(.WIDTH(SLOT_W - 32), .DEPTH(MAX_LIGHTS)) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );
    elk_ram #(.WIDTH(32), .DEPTH(MAX_LIGHTS)) u_score_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sc_wdata),
        .raddr (ram_raddr),
        .rdata (sc_rdata)
    );
    assign sc_wdata = score_reg;
    assign ram_wdata = {px_reg, py_reg, pz_reg, range_reg, cr_reg, cg_reg, cb_reg};
    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_waddr = wr_idx_reg;
    assign ram_raddr = (state_reg == ST_FETCH || state_reg == ST_OUT) ? best_idx_reg
                                                                       : scan_idx_reg;

    assign in_ready = (state_reg == ST_IDLE);

    // axis difference, squared
    logic signed [24:0] diff;
    logic [24:0]        adiff;
    always_comb
    begin
        case (axis_reg)
            2'd0:    diff = 25'(signed'(px_reg)) - 25'(signed'(cam_x_reg));
            2'd1:    diff = 25'(signed'(py_reg)) - 25'(signed'(cam_y_reg));
            default: diff = 25'(signed'(pz_reg)) - 25'(signed'(cam_z_reg));
        endcase
        adiff = diff[24] ? 25'(-diff) : 25'(diff);
    end

    // square root step (one result bit per operand bit pair)
    logic [49:0] sq_trial;
    logic [49:0] sq_rem_sh;
    always_comb
    begin
        sq_rem_sh = {sq_rem_reg[47:0], sq_val_reg[49:48]};
        sq_trial  = sq_rem_sh - {23'd0, sq_res_reg, 2'b01};
    end

    // divide step
    logic [33:0] drem_sh;
    logic [33:0] dtrial;
    always_comb
    begin
        drem_sh = {drem_reg[32:0], num_reg[45]};
        dtrial  = drem_sh - {1'b0, den_reg};
    end

    logic [31:0] slot_score_rd;
    assign slot_score_rd = sc_rdata;

    // weakest-entry scan: last slot lower than the running best, new body strictly better
    logic scan_low;
    logic scan_better;
    assign scan_low    = !best_ok_reg || (slot_score_rd < best_score_reg);
    assign scan_better = scan_low ? (score_reg > slot_score_rd) : (score_reg > best_score_reg);

    logic skip_body;
    assign skip_body = !has_body || (emit_strength <= 16'd40) ||
                       ((emit_r | emit_g | emit_b) == 16'd0);

    // control and datapath sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            kept_reg    <= '0;
            out_valid   <= 1'b0;
            emitted_reg <= '0;
            done_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid && out_ready)
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        px_reg <= pos_x;  py_reg <= pos_y;  pz_reg <= pos_z;
                        rad_reg <= radius; er_reg <= emit_r; eg_reg <= emit_g;
                        eb_reg <= emit_b; st_reg <= emit_strength;
                        fe_reg <= frame_end;
                        emitted_reg <= '0;
                        done_reg <= '0;
                        lume_reg <= lum21(21'(emit_r), 21'(emit_g), 21'(emit_b));
                        mult_reg <= 17'(17'd3482 + 17'((29'(emit_strength) * 29'd5939) >> 12));
                        axis_reg <= 2'd0;
                        sq_acc_reg <= '0;
                        scan_idx_reg <= '0;
                        scan_cnt_reg <= '0;
                        best_ok_reg <= 1'b0;
                    end
                end
                ST_C1:
                begin
                    prod_reg <= 43'(lume_reg) * 43'(st_reg);
                    cr_reg <= 21'((33'(er_reg) * 33'(mult_reg)) >> 12);
                    cg_reg <= 21'((33'(eg_reg) * 33'(mult_reg)) >> 12);
                    cb_reg <= 21'((33'(eb_reg) * 33'(mult_reg)) >> 12);
                    sq_acc_reg <= sq_acc_reg + 50'(48'(adiff) * 48'(adiff));
                    axis_reg <= axis_reg + 2'd1;
                end
                ST_C2:
                begin
                    // t, clamped to one
                    logic [42:0] tt;
                    tt = 43'((47'(prod_reg) * 47'd22938) >> 28);
                    t_reg <= (tt > 43'd4096) ? 13'd4096 : tt[12:0];
                    lumc_reg <= lum21(cr_reg, cg_reg, cb_reg);
                    sq_acc_reg <= sq_acc_reg + 50'(48'(adiff) * 48'(adiff));
                    axis_reg <= axis_reg + 2'd1;
                end
                ST_C3:
                begin
                    logic [38:0] rr;
                    rr = (39'(rad_reg) * (39'd73728 + 39'(t_reg) * 39'd16)) >> 12;
                    range_reg <= (rr < 39'd2048) ? 22'd2048 : rr[21:0];
                    sq_val_reg <= sq_acc_reg + 50'(48'(adiff) * 48'(adiff));
                    sq_rem_reg <= '0;
                    sq_res_reg <= '0;
                    step_reg <= '0;
                end
                ST_SQRT:
                begin
                    sq_val_reg <= {sq_val_reg[47:0], 2'b00};
                    if (!sq_trial[49])
                    begin
                        sq_rem_reg <= sq_trial;
                        sq_res_reg <= {sq_res_reg[23:0], 1'b1};
                    end
                    else
                    begin
                        sq_rem_reg <= sq_rem_sh;
                        sq_res_reg <= {sq_res_reg[23:0], 1'b0};
                    end
                    step_reg <= step_reg + 5'd1;
                end
                ST_DEN:
                begin
                    den_reg <= 33'd65536 + 33'((36'(sq_res_reg) * 36'd1966) >> 8);
                    num_reg <= 46'((46'(lumc_reg) * 46'(range_reg)) << 4);
                    drem_reg <= '0;
                    quo_reg <= '0;
                    dstep_reg <= '0;
                end
                ST_DIV:
                begin
                    num_reg <= {num_reg[44:0], 1'b0};
                    if (!dtrial[33])
                    begin
                        drem_reg <= dtrial;
                        quo_reg <= {quo_reg[44:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= drem_sh;
                        quo_reg <= {quo_reg[44:0], 1'b0};
                    end
                    dstep_reg <= dstep_reg + 6'd1;
                    if (dstep_reg == 6'd45)
                    begin
                        // saturate, pick destination
                        logic [45:0] q;
                        q = {quo_reg[44:0], !dtrial[33]};
                        score_reg <= (q[45:32] != '0) ? 32'hFFFF_FFFF : q[31:0];
                        wr_idx_reg <= AW'(kept_reg);
                        scan_idx_reg <= '0;
                        scan_cnt_reg <= '0;
                        best_ok_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    // weakest entry; read data lags the address by the registered read
                    if (scan_cnt_reg == CNT_FULL)
                    begin
                        wr_idx_reg <= scan_low ? AW'(scan_cnt_reg - CW'(1)) : best_idx_reg;
                        scan_idx_reg <= '0;
                        scan_cnt_reg <= '0;
                        best_ok_reg <= 1'b0;
                    end
                    else
                    begin
                        if (scan_cnt_reg != '0)
                        begin
                            if (scan_low)
                            begin
                                best_score_reg <= slot_score_rd;
                                best_idx_reg <= AW'(scan_cnt_reg - CW'(1));
                                best_ok_reg <= 1'b1;
                            end
                        end
                        scan_idx_reg <= (scan_cnt_reg + CW'(1) < CNT_FULL) ?
                                        AW'(scan_cnt_reg + CW'(1)) : '0;
                        scan_cnt_reg <= scan_cnt_reg + CW'(1);
                    end
                end
                ST_WRITE:
                begin
                    if (kept_reg != CNT_FULL)
                    begin
                        kept_reg <= kept_reg + CW'(1);
                    end
                    scan_idx_reg <= '0;
                    scan_cnt_reg <= '0;
                    best_ok_reg <= 1'b0;
                end
                ST_SEL:
                begin
                    // highest score not yet sent, lowest slot on ties
                    if (scan_cnt_reg != '0 && !done_reg[AW'(scan_cnt_reg - CW'(1))])
                    begin
                        if (!best_ok_reg || slot_score_rd > best_score_reg)
                        begin
                            best_score_reg <= slot_score_rd;
                            best_idx_reg <= AW'(scan_cnt_reg - CW'(1));
                            best_ok_reg <= 1'b1;
                        end
                    end
                    scan_idx_reg <= (scan_cnt_reg + CW'(1) < kept_reg) ?
                                    AW'(scan_cnt_reg + CW'(1)) : '0;
                    scan_cnt_reg <= scan_cnt_reg + CW'(1);
                end
                ST_FETCH:
                begin
                    done_reg[best_idx_reg] <= 1'b1;
                end
                ST_OUT:
                begin
                    if (!out_valid)
                    begin
                        {light_x, light_y, light_z, light_range, light_r, light_g, light_b}
                            <= ram_rdata;
                        light_score <= sc_rdata;
                        rank_last <= (emitted_reg + CW'(1) == kept_reg);
                        out_valid <= 1'b1;
                        emitted_reg <= emitted_reg + CW'(1);
                        scan_idx_reg <= '0;
                        scan_cnt_reg <= '0;
                        best_ok_reg <= 1'b0;
                        if (emitted_reg + CW'(1) == kept_reg)
                        begin
                            kept_reg <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    if (!skip_body)
                        state_next = ST_C1;
                    else if (frame_end && kept_reg != '0)
                        state_next = ST_SEL;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_C1:   state_next = ST_C2;
            ST_C2:   state_next = ST_C3;
            ST_C3:   state_next = ST_SQRT;
            ST_SQRT: state_next = (step_reg == 5'd24) ? ST_DEN : ST_SQRT;
            ST_DEN:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (dstep_reg == 6'd45)
                    state_next = (kept_reg == CNT_FULL) ? ST_SCAN : ST_WRITE;
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == CNT_FULL)
                    state_next = scan_better ? ST_WRITE : (fe_reg ? ST_SEL : ST_IDLE);
            end
            ST_WRITE: state_next = fe_reg ? ST_SEL : ST_IDLE;
            ST_SEL:   state_next = (scan_cnt_reg == kept_reg) ? ST_FETCH : ST_SEL;
            ST_FETCH: state_next = ST_OUT;
            ST_OUT:
            begin
                if (!out_valid)
                    state_next = (emitted_reg + CW'(1) == kept_reg) ? ST_IDLE : ST_SEL;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // checks
    `ELK_ASSERT_IMP(a_no_accept_busy, in_valid && in_ready, state_reg == ST_IDLE,
        "item accepted while busy")
    `ELK_ASSERT_IMP(a_kept_bound, 1'b1, kept_reg <= CNT_FULL, "kept count over capacity")
    `ELK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(light_score),
        "stalled output word changed")
    `ELK_ASSERT_IMP(a_write_bound, ram_we, int'(ram_waddr) < MAX_LIGHTS,
        "slot write out of range")
endmodule

`default_nettype wire
